// ===== design/bis_pkg.sv =====
// Package for the bilinear image scaler: field widths, register codes,
// reset values and the structs passed between the front end, queue and back end.
// Depends on nothing.
package bis_pkg;

   localparam int COORD_BITS     = 12;
   localparam int CHAN_BITS      = 8;
   localparam int PIXEL_BITS     = 32;
   localparam int SIZE_BITS      = 10;
   localparam int STEP_BITS      = 25;
   localparam int POS_BITS       = COORD_BITS + STEP_BITS;
   localparam int FRAC_MAX_BITS  = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 25;

   localparam logic [SIZE_BITS-1:0] SOURCE_SIZE_RESET = 10'd512;
   localparam logic [STEP_BITS-1:0] STEP_RESET        = 25'd65536;

   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_STEP_X        = 2'd2,
      CSR_STEP_Y        = 2'd3
   } bis_csr_index_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] source_width;
      logic [SIZE_BITS-1:0] source_height;
      logic [STEP_BITS-1:0] step_x;
      logic [STEP_BITS-1:0] step_y;
   } bis_cfg_type;

   // One classified item. For a pixel write, col0/row0 carry the target pixel.
   // For a request they carry the upper left neighbour; the *_same bits say the
   // right or lower neighbour is the same pixel because of the image edge.
   typedef struct packed {
      logic                     is_write;
      logic                     wr_ok;
      logic [COORD_BITS-1:0]    col0;
      logic                     col_same;
      logic [COORD_BITS-1:0]    row0;
      logic                     row_same;
      logic [FRAC_MAX_BITS-1:0] frac_x;
      logic [FRAC_MAX_BITS-1:0] frac_y;
      logic [PIXEL_BITS-1:0]    pixel;
      logic [COORD_BITS-1:0]    out_x;
      logic [COORD_BITS-1:0]    out_y;
      logic                     clamped;
   } bis_entry_type;

   typedef struct packed {
      logic empty;
      logic almost_full;
   } bis_queue_status_type;

endpackage

// ===== design/bis_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module bis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bis_queue.sv =====
// Short FIFO that parts the front end from the back end.
// Depends on bis_pkg for the status struct.
module bis_queue
   import bis_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     pop_data,
   output bis_queue_status_type status
);

   localparam int PTR_BITS   = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data           = slot_ff[rd_ptr_ff];
   assign status.empty       = (count_ff == '0);
   assign status.almost_full = (count_ff >= COUNT_BITS'(DEPTH - 1));

endmodule

// ===== design/bis_front.sv =====
// Front end of the scaler: takes commands, forms source positions and
// classifies each item into a queue entry. Depends on bis_pkg.
module bis_front
   import bis_pkg::*;
#(
   parameter int MAX_SOURCE_WIDTH  = 512,
   parameter int MAX_SOURCE_HEIGHT = 512,
   parameter int FRACTION_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [COORD_BITS-1:0] req_coord_x,
   input  logic [COORD_BITS-1:0] req_coord_y,
   input  logic [CHAN_BITS-1:0]  req_red_in,
   input  logic [CHAN_BITS-1:0]  req_green_in,
   input  logic [CHAN_BITS-1:0]  req_blue_in,
   input  logic [CHAN_BITS-1:0]  req_alpha_in,
   input  bis_cfg_type           cfg,
   input  bis_queue_status_type  queue_status,
   output logic                  push,
   output bis_entry_type         entry
);

   localparam int IP_BITS  = POS_BITS - FRACTION_BITS;
   localparam int EFF_BITS = COORD_BITS + 1;

   typedef struct packed {
      logic [COORD_BITS-1:0]    idx;
      logic                     same;
      logic [FRAC_MAX_BITS-1:0] frac;
      logic                     over;
   } axis_type;

   logic                  accept;
   logic                  a_valid_ff, a_valid_in;
   logic                  a_func_ff;
   logic [COORD_BITS-1:0] a_cx_ff, a_cy_ff;
   logic [PIXEL_BITS-1:0] a_pixel_ff;
   logic [POS_BITS-1:0]   a_pos_x_ff, a_pos_x_in;
   logic [POS_BITS-1:0]   a_pos_y_ff, a_pos_y_in;
   axis_type              loc_x, loc_y;

   // Maps a source position onto one axis of the image, clamping at the edge.
   function automatic axis_type locate(input logic [POS_BITS-1:0] pos,
                                       input logic [SIZE_BITS-1:0] size,
                                       input int max_size);
      logic [EFF_BITS-1:0]      eff;
      logic [COORD_BITS-1:0]    last;
      logic [IP_BITS-1:0]       ip;
      logic [FRACTION_BITS-1:0] fp;
      logic                     over;
      axis_type                 r;
      if (size == '0) begin
         eff = EFF_BITS'(1);
      end else if (EFF_BITS'(size) > EFF_BITS'(max_size)) begin
         eff = EFF_BITS'(max_size);
      end else begin
         eff = EFF_BITS'(size);
      end
      last   = COORD_BITS'(eff - EFF_BITS'(1));
      ip     = pos[POS_BITS-1:FRACTION_BITS];
      fp     = pos[FRACTION_BITS-1:0];
      over   = (ip > IP_BITS'(last)) || ((ip == IP_BITS'(last)) && (fp != '0));
      r.over = over;
      r.idx  = over ? last : ip[COORD_BITS-1:0];
      r.same = over || (ip[COORD_BITS-1:0] == last);
      r.frac = over ? '0 : FRAC_MAX_BITS'(fp);
      return r;
   endfunction

   assign busy       = queue_status.almost_full;
   assign accept     = start && !queue_status.almost_full;
   assign a_valid_in = accept;
   assign a_pos_x_in = POS_BITS'(req_coord_x) * POS_BITS'(cfg.step_x);
   assign a_pos_y_in = POS_BITS'(req_coord_y) * POS_BITS'(cfg.step_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_func_ff  <= req_func;
         a_cx_ff    <= req_coord_x;
         a_cy_ff    <= req_coord_y;
         a_pixel_ff <= {req_alpha_in, req_blue_in, req_green_in, req_red_in};
         a_pos_x_ff <= a_pos_x_in;
         a_pos_y_ff <= a_pos_y_in;
      end
   end

   assign loc_x = locate(a_pos_x_ff, cfg.source_width, MAX_SOURCE_WIDTH);
   assign loc_y = locate(a_pos_y_ff, cfg.source_height, MAX_SOURCE_HEIGHT);

   always_comb begin
      entry.is_write = (a_func_ff == FUNC_WRITE);
      entry.wr_ok    = (EFF_BITS'(a_cx_ff) < EFF_BITS'(MAX_SOURCE_WIDTH))
                    && (EFF_BITS'(a_cy_ff) < EFF_BITS'(MAX_SOURCE_HEIGHT));
      entry.col0     = entry.is_write ? a_cx_ff : loc_x.idx;
      entry.col_same = loc_x.same;
      entry.row0     = entry.is_write ? a_cy_ff : loc_y.idx;
      entry.row_same = loc_y.same;
      entry.frac_x   = loc_x.frac;
      entry.frac_y   = loc_y.frac;
      entry.pixel    = a_pixel_ff;
      entry.out_x    = a_cx_ff;
      entry.out_y    = a_cy_ff;
      entry.clamped  = loc_x.over || loc_y.over;
   end

   assign push = a_valid_ff;

endmodule

// ===== design/bis_back.sv =====
// Back end of the scaler: four parity banks of the source image, the neighbour
// read, the two blend stages and the rounding. Depends on bis_pkg and bis_ram.
module bis_back
   import bis_pkg::*;
#(
   parameter int MAX_SOURCE_WIDTH  = 512,
   parameter int MAX_SOURCE_HEIGHT = 512,
   parameter int FRACTION_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bis_queue_status_type  queue_status,
   input  bis_entry_type         head,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [CHAN_BITS-1:0]  rsp_red_out,
   output logic [CHAN_BITS-1:0]  rsp_green_out,
   output logic [CHAN_BITS-1:0]  rsp_blue_out,
   output logic [CHAN_BITS-1:0]  rsp_alpha_out,
   output logic [COORD_BITS-1:0] rsp_out_x,
   output logic [COORD_BITS-1:0] rsp_out_y,
   output logic                  rsp_clamped
);

   localparam int HALF_W     = (MAX_SOURCE_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_SOURCE_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int ADDR_BITS  = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
   localparam int W_BITS     = FRACTION_BITS + 1;
   localparam int TOP_BITS   = CHAN_BITS + FRACTION_BITS + 1;
   localparam int SUM_BITS   = TOP_BITS + FRACTION_BITS + 1;
   localparam logic [W_BITS-1:0]   ONE  = W_BITS'(1) << FRACTION_BITS;
   localparam logic [SUM_BITS-1:0] HALF = SUM_BITS'(1) << (2 * FRACTION_BITS - 1);

   logic [COORD_BITS-1:0] col1, row1;
   logic [PIXEL_BITS-1:0] bank_data [4];

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_col0p_ff, s1_col_same_ff, s1_row0p_ff, s1_row_same_ff;
   logic [FRACTION_BITS-1:0] s1_fx_ff, s1_fy_ff;
   logic [COORD_BITS-1:0]    s1_x_ff, s1_y_ff;
   logic                     s1_clamped_ff;

   logic                  col1p, row1p;
   logic [PIXEL_BITS-1:0] pa, pb, pc, pd;
   logic [W_BITS-1:0]     wx0, wx1;
   logic [TOP_BITS-1:0]   top_in [4];
   logic [TOP_BITS-1:0]   bot_in [4];

   logic                     s2_valid_ff;
   logic [TOP_BITS-1:0]      s2_top_ff [4];
   logic [TOP_BITS-1:0]      s2_bot_ff [4];
   logic [FRACTION_BITS-1:0] s2_fy_ff;
   logic [COORD_BITS-1:0]    s2_x_ff, s2_y_ff;
   logic                     s2_clamped_ff;

   logic [W_BITS-1:0]     wy0, wy1;
   logic [SUM_BITS-1:0]   sum_in [4];

   logic                  s3_valid_ff;
   logic [SUM_BITS-1:0]   s3_sum_ff [4];
   logic [COORD_BITS-1:0] s3_x_ff, s3_y_ff;
   logic                  s3_clamped_ff;

   logic                  out_valid_ff;
   logic [CHAN_BITS-1:0]  out_chan_ff [4];
   logic [CHAN_BITS-1:0]  out_chan_in [4];
   logic [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic                  out_clamped_ff;

   // The back end never stalls, so every queued entry is taken at once.
   assign pop  = !queue_status.empty;
   assign col1 = head.col_same ? head.col0 : head.col0 + COORD_BITS'(1);
   assign row1 = head.row_same ? head.row0 : head.row0 + COORD_BITS'(1);

   // Bank index is {row parity, column parity}. Each bank reads whichever of the
   // two neighbour columns and rows has its parity; a write lands in one bank.
   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic RX = 1'(b % 2);
      localparam logic RY = 1'(b / 2);
      logic [COORD_BITS-1:0] col_sel, row_sel;
      logic [ADDR_BITS-1:0]  addr;
      logic                  wr_en;

      assign col_sel = (head.col0[0] == RX) ? head.col0 : col1;
      assign row_sel = (head.row0[0] == RY) ? head.row0 : row1;
      assign addr    = ADDR_BITS'(32'(row_sel >> 1) * HALF_W) + ADDR_BITS'(col_sel >> 1);
      assign wr_en   = pop && head.is_write && head.wr_ok
                    && (head.col0[0] == RX) && (head.row0[0] == RY);

      bis_ram #(
         .WIDTH (PIXEL_BITS),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (addr),
         .wr_data (head.pixel),
         .rd_addr (addr),
         .rd_data (bank_data[b])
      );
   end

   assign s1_valid_in = pop && !head.is_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_col0p_ff    <= head.col0[0];
      s1_col_same_ff <= head.col_same;
      s1_row0p_ff    <= head.row0[0];
      s1_row_same_ff <= head.row_same;
      s1_fx_ff       <= head.frac_x[FRACTION_BITS-1:0];
      s1_fy_ff       <= head.frac_y[FRACTION_BITS-1:0];
      s1_x_ff        <= head.out_x;
      s1_y_ff        <= head.out_y;
      s1_clamped_ff  <= head.clamped;
   end

   // Horizontal blend. At the edge the second neighbour is the first one.
   always_comb begin
      col1p = s1_col_same_ff ? s1_col0p_ff : !s1_col0p_ff;
      row1p = s1_row_same_ff ? s1_row0p_ff : !s1_row0p_ff;
      pa  = s1_row0p_ff ? (s1_col0p_ff ? bank_data[3] : bank_data[2])
                        : (s1_col0p_ff ? bank_data[1] : bank_data[0]);
      pb  = s1_row0p_ff ? (col1p ? bank_data[3] : bank_data[2])
                        : (col1p ? bank_data[1] : bank_data[0]);
      pc  = row1p ? (s1_col0p_ff ? bank_data[3] : bank_data[2])
                  : (s1_col0p_ff ? bank_data[1] : bank_data[0]);
      pd  = row1p ? (col1p ? bank_data[3] : bank_data[2])
                  : (col1p ? bank_data[1] : bank_data[0]);
      wx1 = W_BITS'(s1_fx_ff);
      wx0 = ONE - wx1;
      for (int k = 0; k < 4; k++) begin
         top_in[k] = TOP_BITS'(pa[CHAN_BITS*k +: CHAN_BITS]) * TOP_BITS'(wx0)
                   + TOP_BITS'(pb[CHAN_BITS*k +: CHAN_BITS]) * TOP_BITS'(wx1);
         bot_in[k] = TOP_BITS'(pc[CHAN_BITS*k +: CHAN_BITS]) * TOP_BITS'(wx0)
                   + TOP_BITS'(pd[CHAN_BITS*k +: CHAN_BITS]) * TOP_BITS'(wx1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         s2_top_ff[k] <= top_in[k];
         s2_bot_ff[k] <= bot_in[k];
      end
      s2_fy_ff      <= s1_fy_ff;
      s2_x_ff       <= s1_x_ff;
      s2_y_ff       <= s1_y_ff;
      s2_clamped_ff <= s1_clamped_ff;
   end

   // Vertical blend, still exact.
   always_comb begin
      wy1 = W_BITS'(s2_fy_ff);
      wy0 = ONE - wy1;
      for (int k = 0; k < 4; k++) begin
         sum_in[k] = SUM_BITS'(s2_top_ff[k]) * SUM_BITS'(wy0)
                   + SUM_BITS'(s2_bot_ff[k]) * SUM_BITS'(wy1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         s3_sum_ff[k] <= sum_in[k];
      end
      s3_x_ff       <= s2_x_ff;
      s3_y_ff       <= s2_y_ff;
      s3_clamped_ff <= s2_clamped_ff;
   end

   // Round half up and drop both fractions.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         out_chan_in[k] = CHAN_BITS'((s3_sum_ff[k] + HALF) >> (2 * FRACTION_BITS));
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         out_chan_ff[k] <= out_chan_in[k];
      end
      out_x_ff       <= s3_x_ff;
      out_y_ff       <= s3_y_ff;
      out_clamped_ff <= s3_clamped_ff;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = out_chan_ff[0];
   assign rsp_green_out = out_chan_ff[1];
   assign rsp_blue_out  = out_chan_ff[2];
   assign rsp_alpha_out = out_chan_ff[3];
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_clamped   = out_clamped_ff;

endmodule

// ===== design/bilinear_image_scaler_unit.sv =====
// Bilinear image scaler, top level: configuration registers and the wiring of
// front end, queue and back end. Depends on bis_pkg, bis_front, bis_queue, bis_back.
//
// The unit takes one command per clock: a pixel write (func 0) or a request
// for one scaled output pixel (func 1), transferred at an edge with start high
// and busy low. Requests are answered in order, one result per request and
// none per write, each shown for exactly one cycle with rsp_valid high; the
// receiver must take it then. Because the source image sits in four banks split
// by row and column parity, all four neighbours are read in the same cycle and the
// unit sustains one command per clock; busy stays low in normal use. Between the
// edge that transfers a request and its result strobe lie the position product
// register, a queue slot, the bank read register, the two blend registers and the
// rounding register. The image store has no reset: a request must only reach pixels
// written before. Write the csr_ registers only while no request is in flight.
module bilinear_image_scaler_unit
   import bis_pkg::*;
#(
   parameter int MAX_SOURCE_WIDTH  = 512,
   parameter int MAX_SOURCE_HEIGHT = 512,
   parameter int FRACTION_BITS     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic [COORD_BITS-1:0]     req_coord_x,
   input  logic [COORD_BITS-1:0]     req_coord_y,
   input  logic [CHAN_BITS-1:0]      req_red_in,
   input  logic [CHAN_BITS-1:0]      req_green_in,
   input  logic [CHAN_BITS-1:0]      req_blue_in,
   input  logic [CHAN_BITS-1:0]      req_alpha_in,
   output logic                      rsp_valid,
   output logic [CHAN_BITS-1:0]      rsp_red_out,
   output logic [CHAN_BITS-1:0]      rsp_green_out,
   output logic [CHAN_BITS-1:0]      rsp_blue_out,
   output logic [CHAN_BITS-1:0]      rsp_alpha_out,
   output logic [COORD_BITS-1:0]     rsp_out_x,
   output logic [COORD_BITS-1:0]     rsp_out_y,
   output logic                      rsp_clamped,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int QUEUE_DEPTH = 4;

   bis_cfg_type          cfg_ff, cfg_in;
   bis_queue_status_type queue_status;
   bis_entry_type        push_entry, head_entry;
   logic                 push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (bis_csr_index_type'(csr_index))
            CSR_SOURCE_WIDTH:  cfg_in.source_width  = csr_data[SIZE_BITS-1:0];
            CSR_SOURCE_HEIGHT: cfg_in.source_height = csr_data[SIZE_BITS-1:0];
            CSR_STEP_X:        cfg_in.step_x        = csr_data[STEP_BITS-1:0];
            CSR_STEP_Y:        cfg_in.step_y        = csr_data[STEP_BITS-1:0];
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= SOURCE_SIZE_RESET;
         cfg_ff.source_height <= SOURCE_SIZE_RESET;
         cfg_ff.step_x        <= STEP_RESET;
         cfg_ff.step_y        <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bis_front #(
      .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
      .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
      .FRACTION_BITS     (FRACTION_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .req_alpha_in (req_alpha_in),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .push         (push),
      .entry        (push_entry)
   );

   bis_queue #(
      .WIDTH ($bits(bis_entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (head_entry),
      .status    (queue_status)
   );

   bis_back #(
      .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
      .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
      .FRACTION_BITS     (FRACTION_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .head          (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_alpha_out (rsp_alpha_out),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_clamped   (rsp_clamped)
   );

endmodule
